[src/brm_pkg.sv]
`timescale 1ns / 1ps
// brm_pkg: shared types and constants for the background range model update
// no dependencies; imported by the entry store, the update unit and the top level
package brm_pkg;

  localparam int IDX_W = 16;
  localparam int VAL_W = 8;
  localparam int MODE_W = 3;

  localparam logic [VAL_W-1:0] SAT_MAX = 8'hFF;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_INIT      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GROW_SLOW = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GROW_FAST = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ADJUST    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SHIFT     = 3'd5;

  // input item
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  pixel_index;
    logic [VAL_W-1:0]  pixel_value;
    logic              update_enable;
  } brm_in_t;

  // result item
  typedef struct packed {
    logic [VAL_W-1:0] low_bound_out;
    logic [VAL_W-1:0] high_bound_out;
    logic [VAL_W-1:0] below_count_out;
    logic [VAL_W-1:0] above_count_out;
  } brm_out_t;

  // one model entry as held in the store
  typedef struct packed {
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] bc;
    logic [VAL_W-1:0] ac;
  } brm_entry_t;

endpackage

[src/background_range_model_update.sv]
`timescale 1ns / 1ps
// background_range_model_update: top level of the per-pixel range model pipeline
// depends on brm_pkg, brm_store and brm_update
//
// usage
//   in_valid/in_ready carry one item (mode, pixel index, value, enable) per transfer.
//   out_valid/out_ready: one result per item, the new entry, zeros if out of range.
//   cfg_valid/cfg_ready write count_threshold; cfg_ready is always high and the
//   register is meant to change only while no item is in flight.
// timing
//   three register stages: entry read, operand select, update and write-back into
//   the output register. throughput is one item per cycle while the output is not
//   stalled, set by the separate read and write ports of the entry store;
//   back-to-back items on one pixel are forwarded from the output stage, so
//   they need no bubbles.
// reset
//   rst_n clears the stage valid bits and the threshold. the store is not
//   cleared: every pixel must see an init item before any other mode.
// stall
//   when a result waits and out_ready is low the pipeline holds, with no store
//   write; in_ready stays high until the first stage is also occupied.
module background_range_model_update #(
  parameter int FRAME_PIXELS = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  brm_pkg::brm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output brm_pkg::brm_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import brm_pkg::*;

  localparam int DEPTH  = (FRAME_PIXELS < (1 << IDX_W)) ? FRAME_PIXELS : (1 << IDX_W);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] thr_r;

  // stage 1: item and raw entry read
  logic       s1_valid_r;
  brm_in_t    s1_item_r;
  logic       s1_in_range_r;
  brm_entry_t s1_rd;

  // stage 2: item and forwarded operand
  logic       s2_valid_r;
  brm_in_t    s2_item_r;
  logic       s2_in_range_r;
  brm_entry_t s2_op_r;

  // stage 3: output register plus entry kept for forwarding
  logic             out_valid_r;
  brm_out_t         out_data_r;
  brm_entry_t       s3_entry_r;
  logic [IDX_W-1:0] s3_idx_r;

  logic       advance;
  logic       in_xfer;
  logic       in_range;
  brm_entry_t s1_op;
  brm_entry_t s2_op;
  brm_entry_t s2_new;
  logic       wr_en;

  // whole pipeline moves when the output register is free or being taken
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance || !s1_valid_r;
  assign in_xfer   = in_valid && in_ready;
  assign in_range  = 32'(in_data.pixel_index) < FRAME_PIXELS;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  brm_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .rd_en     (in_xfer),
    .rd_addr   (in_data.pixel_index[ADDR_W-1:0]),
    .rd_data_r (s1_rd),
    .wr_en     (wr_en),
    .wr_addr   (s2_item_r.pixel_index[ADDR_W-1:0]),
    .wr_data   (s2_new)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r     <= in_data;
      s1_in_range_r <= in_range;
    end
  end

  // forward the entry just written by the item in the output stage
  assign s1_op = (out_valid_r && s3_idx_r == s1_item_r.pixel_index) ? s3_entry_r : s1_rd;

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_item_r     <= s1_item_r;
      s2_in_range_r <= s1_in_range_r;
      s2_op_r       <= s1_op;
    end
  end

  // forward from the immediately older item, now in the output stage
  assign s2_op = (out_valid_r && s3_idx_r == s2_item_r.pixel_index) ? s3_entry_r : s2_op_r;

  brm_update u_update (
    .item            (s2_item_r),
    .cur             (s2_op),
    .count_threshold (thr_r),
    .nxt             (s2_new)
  );

  assign wr_en = advance && s2_valid_r && s2_in_range_r;

  // stage 3 registers, out-of-range pixels report zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_entry_r <= s2_new;
      s3_idx_r   <= s2_item_r.pixel_index;
      if (s2_in_range_r) begin
        out_data_r <= {s2_new.lo, s2_new.hi, s2_new.bc, s2_new.ac};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  // no store write while the output side is stalled
  a_no_write_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> !wr_en)
    else $error("store written while the pipeline is stalled");

  // input is held off only when the first stage is full and the output stalls
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && s1_valid_r))
    else $error("input held off without an output stall");

  // a stalled stage 2 item is still there on the next cycle
  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !advance) |=> (s2_valid_r && $stable(s2_item_r)))
    else $error("stage 2 item lost during a stall");

  // pipeline empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !s2_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

endmodule

[src/brm_store.sv]
`timescale 1ns / 1ps
// brm_store: per-pixel entry memory, one write port and one registered read port
// depends on brm_pkg for the entry type
module brm_store #(
  parameter  int DEPTH  = 65536,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output brm_pkg::brm_entry_t       rd_data_r,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  brm_pkg::brm_entry_t       wr_data
);
  import brm_pkg::*;

  brm_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while the read is not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[src/brm_update.sv]
`timescale 1ns / 1ps
// brm_update: computes the new entry for one item from its operand entry
// depends on brm_pkg for modes, types and the saturation limit
module brm_update (
  input  brm_pkg::brm_in_t     item,
  input  brm_pkg::brm_entry_t  cur,
  input  logic [7:0]           count_threshold,
  output brm_pkg::brm_entry_t  nxt
);
  import brm_pkg::*;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? SAT_MAX : s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  logic [VAL_W-1:0] v;
  logic             below;
  logic             above;
  logic [VAL_W-1:0] up_amt;
  logic [VAL_W-1:0] down_amt;

  assign v        = item.pixel_value;
  assign below    = v < cur.lo;
  assign above    = v > cur.hi;
  assign up_amt   = sat_sub(v, cur.hi);
  assign down_amt = sat_sub(cur.lo, v);

  // mode decode
  always_comb begin
    nxt = cur;
    unique case (item.mode)
      MODE_INIT: begin
        nxt.lo = v;
        nxt.hi = v;
        nxt.bc = '0;
        nxt.ac = '0;
      end
      MODE_GROW_SLOW: begin
        if (below) nxt.lo = cur.lo - 8'd1;
        if (above) nxt.hi = cur.hi + 8'd1;
      end
      MODE_GROW_FAST: begin
        if (below) nxt.lo = v;
        if (above) nxt.hi = v;
      end
      MODE_COUNT: begin
        if (below && cur.bc != SAT_MAX) nxt.bc = cur.bc + 8'd1;
        if (above && cur.ac != SAT_MAX) nxt.ac = cur.ac + 8'd1;
      end
      MODE_ADJUST: begin
        if (item.update_enable) begin
          if (cur.bc > count_threshold) nxt.lo = sat_sub(cur.lo, 8'd1);
          else if (cur.bc < count_threshold) nxt.lo = sat_add(cur.lo, 8'd1);
          if (cur.ac > count_threshold) nxt.hi = sat_add(cur.hi, 8'd1);
          else if (cur.ac < count_threshold) nxt.hi = sat_sub(cur.hi, 8'd1);
        end
        nxt.bc = '0;
        nxt.ac = '0;
      end
      MODE_SHIFT: begin
        if (item.update_enable) begin
          nxt.lo = sat_sub(sat_add(cur.lo, up_amt), down_amt);
          nxt.hi = sat_sub(sat_add(cur.hi, up_amt), down_amt);
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
